// ===== hdl/rc4_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the RC4 cipher.
package rc4_pkg;

    // Permutation size and its index width.
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW = 8;
    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

    // Default key store depth.
    localparam int DEFAULT_MAX_KEY_BYTES = 256;

    // Item kinds carried in tuser.
    localparam logic FUNC_KEY = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_data;  // latch a data byte, read S[i+1]
        logic accept_key;   // store a key byte
        logic rd_j;         // take S[i], read S[j]
        logic swap;         // write S[i], read S[S[i]+S[j]]
        logic emit;         // write S[j], load the output register
        logic ks_init;      // restore identity, clear schedule counters
        logic ks_rd_a;      // read S[a] and the key byte
        logic ks_rd_b;      // update b, read S[b]
        logic ks_wr_a;      // write S[a]
        logic ks_wr_b;      // write S[b], advance a
    } rc4_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic ks_last;      // key schedule is on its final step
    } rc4_stat_t;

endpackage

// ===== hdl/rc4_ctrl.sv =====
// Controller state machine that sequences data requests and the key schedule.
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      func,
    input  logic      key_last,
    input  rc4_stat_t stat,
    output logic      s_tready,
    output rc4_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RD_J     = 9'b000000010,
        ST_SWAP     = 9'b000000100,
        ST_EMIT     = 9'b000001000,
        ST_KS_INIT  = 9'b000010000,
        ST_KS_RD_A  = 9'b000100000,
        ST_KS_RD_B  = 9'b001000000,
        ST_KS_WR_A  = 9'b010000000,
        ST_KS_WR_B  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Requests are taken only between operations.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tready && s_tvalid;

    // Commands decoded from the current state.
    always_comb
    begin
        cmd             = '0;
        cmd.accept_data = accept && (func == FUNC_DATA);
        cmd.accept_key  = accept && (func == FUNC_KEY);
        cmd.rd_j        = (state_reg == ST_RD_J);
        cmd.swap        = (state_reg == ST_SWAP);
        cmd.emit        = (state_reg == ST_EMIT) && stat.out_free;
        cmd.ks_init     = (state_reg == ST_KS_INIT);
        cmd.ks_rd_a     = (state_reg == ST_KS_RD_A);
        cmd.ks_rd_b     = (state_reg == ST_KS_RD_B);
        cmd.ks_wr_a     = (state_reg == ST_KS_WR_A);
        cmd.ks_wr_b     = (state_reg == ST_KS_WR_B);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_DATA)
                        state_next = ST_RD_J;
                    else if (key_last)
                        state_next = ST_KS_INIT;
                end
            end
            ST_RD_J:    state_next = ST_SWAP;
            ST_SWAP:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_KS_INIT: state_next = ST_KS_RD_A;
            ST_KS_RD_A: state_next = ST_KS_RD_B;
            ST_KS_RD_B: state_next = ST_KS_WR_A;
            ST_KS_WR_A: state_next = ST_KS_WR_B;
            ST_KS_WR_B: state_next = stat.ks_last ? ST_IDLE : ST_KS_RD_A;
            default:    state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/rc4_datapath.sv =====
// Datapath with the permutation and key memories, indices and output register.
module rc4_datapath
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEFAULT_MAX_KEY_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  rc4_cmd_t   cmd,
    input  logic [7:0] in_byte,
    input  logic       m_tready,
    output logic       m_tvalid,
    output logic [7:0] m_tdata,
    output rc4_stat_t  stat
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_CW = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [KEY_CW-1:0] KEY_MAX = KEY_CW'(MAX_KEY_BYTES);

    // Permutation memory; an entry never written since the last identity
    // restore reads as its own address.
    logic [7:0]            perm_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] perm_vld_reg;
    logic [7:0]            perm_q_reg;
    logic [PERM_AW-1:0]    perm_raddr_reg;
    logic                  perm_qvld_reg;

    // Key memory.
    logic [7:0]            key_mem [MAX_KEY_BYTES];
    logic [7:0]            key_q_reg;
    logic [KEY_CW-1:0]     key_count_reg;
    logic [KEY_AW-1:0]     pos_reg;
    logic [KEY_CW-1:0]     pos_inc;

    // Generator and schedule state.
    logic [PERM_AW-1:0]    i_reg;
    logic [PERM_AW-1:0]    j_reg;
    logic [PERM_AW-1:0]    a_reg;
    logic [PERM_AW-1:0]    b_reg;
    logic [7:0]            data_reg;
    logic [7:0]            si_reg;
    logic [7:0]            sj_reg;
    logic [PERM_AW-1:0]    t_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;

    logic [7:0]            rd_val;
    logic [PERM_AW-1:0]    i_inc;
    logic [PERM_AW-1:0]    j_sum;
    logic [PERM_AW-1:0]    t_sum;
    logic [PERM_AW-1:0]    b_sum;
    logic [7:0]            ks;
    logic                  rd_en;
    logic [PERM_AW-1:0]    rd_addr;
    logic                  wr_en;
    logic [PERM_AW-1:0]    wr_addr;
    logic [7:0]            wr_data;
    logic                  key_room;

    // Arithmetic on the indices.
    assign rd_val   = perm_qvld_reg ? perm_q_reg : perm_raddr_reg;
    assign i_inc    = i_reg + PERM_AW'(1);
    assign j_sum    = j_reg + rd_val;
    assign t_sum    = si_reg + rd_val;
    assign b_sum    = b_reg + rd_val + key_q_reg;
    assign pos_inc  = KEY_CW'(pos_reg) + KEY_CW'(1);
    assign key_room = (key_count_reg < KEY_MAX);

    // Keystream byte: the swap of S[i] and S[j] is not yet fully in memory
    // when S[t] is read, so those two entries are forwarded.
    assign ks = (t_reg == j_reg) ? si_reg :
                (t_reg == i_reg) ? sj_reg : rd_val;

    // Permutation read port address.
    always_comb
    begin
        rd_en = cmd.accept_data || cmd.rd_j || cmd.swap || cmd.ks_rd_a || cmd.ks_rd_b;
        if (cmd.accept_data)
            rd_addr = i_inc;
        else if (cmd.rd_j)
            rd_addr = j_sum;
        else if (cmd.swap)
            rd_addr = t_sum;
        else if (cmd.ks_rd_a)
            rd_addr = a_reg;
        else
            rd_addr = b_sum;
    end

    // Permutation write port.
    always_comb
    begin
        wr_en = cmd.swap || cmd.emit || cmd.ks_wr_a || cmd.ks_wr_b;
        if (cmd.swap)
        begin
            wr_addr = i_reg;
            wr_data = rd_val;
        end
        else if (cmd.emit)
        begin
            wr_addr = j_reg;
            wr_data = si_reg;
        end
        else if (cmd.ks_wr_a)
        begin
            wr_addr = a_reg;
            wr_data = rd_val;
        end
        else
        begin
            wr_addr = b_reg;
            wr_data = si_reg;
        end
    end

    // Permutation memory array with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            perm_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            perm_q_reg     <= perm_mem[rd_addr];
            perm_raddr_reg <= rd_addr;
        end
    end

    // Written flags; clearing them restores the identity permutation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_vld_reg  <= '0;
            perm_qvld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ks_init)
                perm_vld_reg <= '0;
            else if (wr_en)
                perm_vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                perm_qvld_reg <= perm_vld_reg[rd_addr];
        end
    end

    // Key memory array with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_key && key_room)
            key_mem[key_count_reg[KEY_AW-1:0]] <= in_byte;
        if (cmd.ks_rd_a)
            key_q_reg <= key_mem[pos_reg];
    end

    // Indices, key count and schedule counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            pos_reg       <= '0;
            key_count_reg <= '0;
        end
        else
        begin
            if (cmd.accept_data)
                i_reg <= i_inc;
            if (cmd.rd_j)
                j_reg <= j_sum;
            if (cmd.accept_key && key_room)
                key_count_reg <= key_count_reg + KEY_CW'(1);
            if (cmd.ks_init)
            begin
                a_reg   <= '0;
                b_reg   <= '0;
                pos_reg <= '0;
            end
            if (cmd.ks_rd_b)
                b_reg <= b_sum;
            if (cmd.ks_wr_b)
            begin
                a_reg   <= a_reg + PERM_AW'(1);
                pos_reg <= (pos_inc == key_count_reg) ? '0 : pos_inc[KEY_AW-1:0];
                // End of the schedule restarts the generator.
                if (stat.ks_last)
                begin
                    i_reg         <= '0;
                    j_reg         <= '0;
                    key_count_reg <= '0;
                end
            end
        end
    end

    // Operand registers of the current request.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_data)
            data_reg <= in_byte;
        if (cmd.rd_j || cmd.ks_rd_b)
            si_reg <= rd_val;
        if (cmd.swap)
        begin
            sj_reg <= rd_val;
            t_reg  <= t_sum;
        end
        if (cmd.emit)
            out_byte_reg <= data_reg ^ ks;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_byte_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.ks_last  = (a_reg == PERM_LAST);

endmodule

// ===== hdl/rc4_stream_cipher.sv =====
// Data byte: result loaded into the output register in the emit state, after the
// read-j and swap states, later while a full output register waits for the receiver.
// The next request follows a data byte only after three dependent permutation reads
// and the write-back of S[j]. A key byte other than the last leaves the input open;
// the last holds it through the identity restore, then 256 schedule steps.
// Asynchronous active-low reset restores identity and clears indices, key count, output.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEFAULT_MAX_KEY_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic [0:0] s_tuser,     // [0] func
    input  logic       s_tlast,     // key_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [7:0] out_byte
);

    rc4_cmd_t  cmd;
    rc4_stat_t stat;

    // Sequencer.
    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser[0]),
        .key_last (s_tlast),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Memories and arithmetic.
    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_byte  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // A data request or a last key byte keeps the input closed next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == FUNC_DATA || s_tlast)) |=> !s_tready)
        else $error("input taken while an operation is in progress");

    // A finished keystream step always shows a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("result lost at the output register");

    // The final schedule step hands control back to the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ks_wr_b && stat.ks_last) |=> s_tready)
        else $error("key schedule did not return to idle");
`endif

endmodule
